### hdl/rsd_pkg.sv
package rsd_pkg;

	// operand and result widths
	localparam int unsigned RSD_DVD_W = 64;
	localparam int unsigned RSD_DVS_W = 32;
	localparam int unsigned RSD_QUO_W = 32;

	// one restoring step per dividend bit
	localparam int unsigned RSD_DIV_STEPS = RSD_DVD_W;

	// default number of restoring steps folded into one pipeline stage
	localparam int unsigned RSD_STEPS_PER_STAGE = 4;

	// control that travels alongside each request
	typedef struct packed {
		logic valid;
		logic neg;
		logic zero;
	} rsd_ctl_t;

endpackage

### hdl/rsd_prep.sv
module rsd_prep
	import rsd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [RSD_DVD_W-1:0] dividend,
	input  logic signed [RSD_DVS_W-1:0] divisor,
	output rsd_ctl_t                   ctl_s1,
	output logic [RSD_DVD_W-1:0]       num_s1,
	output logic [RSD_DVS_W-1:0]       dvs_s1
);

	logic                 a_neg;
	logic                 b_neg;
	logic [RSD_DVD_W-1:0] ua;
	logic [RSD_DVS_W-1:0] ub;
	logic [RSD_DVD_W-1:0] sum;

	// magnitudes; the most negative values map to 2^63 and 2^31 exactly
	always_comb begin
		a_neg = dividend[RSD_DVD_W-1];
		b_neg = divisor[RSD_DVS_W-1];
		ua    = a_neg ? (~dividend + 1'b1) : dividend;
		ub    = b_neg ? (~divisor + 1'b1) : divisor;
		// half the divisor added for round half away from zero; cannot wrap
		sum   = ua + {{(RSD_DVD_W-RSD_DVS_W){1'b0}}, 1'b0, ub[RSD_DVS_W-1:1]};
	end

	// control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start;
			ctl_s1.neg   <= a_neg ^ b_neg;
			ctl_s1.zero  <= (divisor == '0);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		num_s1 <= sum;
		dvs_s1 <= ub;
	end

endmodule

### hdl/rsd_div_stage.sv
module rsd_div_stage
	import rsd_pkg::*;
#(
	parameter int unsigned STEPS = RSD_STEPS_PER_STAGE
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsd_ctl_t             ctl_in,
	input  logic [RSD_DVD_W-1:0] num_in,
	input  logic [RSD_DVS_W-1:0] rem_in,
	input  logic [RSD_DVS_W-1:0] dvs_in,
	output rsd_ctl_t             ctl_sn,
	output logic [RSD_DVD_W-1:0] num_sn,
	output logic [RSD_DVS_W-1:0] rem_sn,
	output logic [RSD_DVS_W-1:0] dvs_sn
);

	logic [RSD_DVD_W-1:0] num_c;
	logic [RSD_DVS_W-1:0] rem_c;
	logic [RSD_DVS_W:0]   cur;
	logic [RSD_DVS_W:0]   diff;

	// restoring steps: num shifts out dividend bits at the top and takes
	// quotient bits in at the bottom; the remainder stays below the divisor when it is nonzero
	always_comb begin
		num_c = num_in;
		rem_c = rem_in;
		cur   = '0;
		diff  = '0;
		for (int unsigned i = 0; i < STEPS; i++) begin
			cur  = {rem_c, num_c[RSD_DVD_W-1]};
			diff = cur - {1'b0, dvs_in};
			if (!diff[RSD_DVS_W]) begin
				rem_c = diff[RSD_DVS_W-1:0];
				num_c = {num_c[RSD_DVD_W-2:0], 1'b1};
			end else begin
				rem_c = cur[RSD_DVS_W-1:0];
				num_c = {num_c[RSD_DVD_W-2:0], 1'b0};
			end
		end
	end

	// control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sn <= '0;
		end else begin
			ctl_sn <= ctl_in;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		num_sn <= num_c;
		rem_sn <= rem_c;
		dvs_sn <= dvs_in;
	end

endmodule

### hdl/rsd_post.sv
module rsd_post
	import rsd_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsd_ctl_t                    ctl_in,
	input  logic [RSD_DVD_W-1:0]        num_in,
	output logic                        done_q,
	output logic signed [RSD_QUO_W-1:0] quotient_q
);

	logic [RSD_QUO_W-1:0] mag;
	logic [RSD_QUO_W-1:0] res;

	// low bits of the quotient, sign applied, zero divisor forced to zero
	always_comb begin
		mag = num_in[RSD_QUO_W-1:0];
		if (ctl_in.zero) begin
			res = '0;
		end else if (ctl_in.neg) begin
			res = ~mag + 1'b1;
		end else begin
			res = mag;
		end
	end

	// strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_in.valid;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		quotient_q <= res;
	end

endmodule

### hdl/rounded_signed_divide_64by32.sv
// Channel  | Ports                         | Handshake
// ---------+-------------------------------+-------------------------------------
// request  | dividend[63:0], divisor[31:0] | taken at a clock edge with start && !busy
// result   | quotient[31:0]                | done high for one cycle, no back-pressure
//
// One request may enter every cycle; busy is never raised.
// The pipeline has one operand stage, the restoring divider stages of
// STEPS_PER_STAGE subtract steps each, and one sign and result stage.
// The subtract chain in a divider stage sets the clock.
// arst_n clears the control bits only; requests in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module rounded_signed_divide_64by32
	import rsd_pkg::*;
#(
	parameter int unsigned STEPS_PER_STAGE = RSD_STEPS_PER_STAGE
)
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [RSD_DVD_W-1:0] dividend,
	input  logic signed [RSD_DVS_W-1:0] divisor,
	output logic                        done,
	output logic signed [RSD_QUO_W-1:0] quotient
);

	localparam int unsigned N_STAGES = RSD_DIV_STEPS / STEPS_PER_STAGE;
	localparam int unsigned LATENCY  = N_STAGES + 2;

	rsd_ctl_t             ctl_w [0:N_STAGES];
	logic [RSD_DVD_W-1:0] num_w [0:N_STAGES];
	logic [RSD_DVS_W-1:0] rem_w [0:N_STAGES];
	logic [RSD_DVS_W-1:0] dvs_w [0:N_STAGES];

	// pipeline always accepts
	assign busy = 1'b0;

	// operand magnitudes and rounding offset
	rsd_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (dividend),
		.divisor  (divisor),
		.ctl_s1   (ctl_w[0]),
		.num_s1   (num_w[0]),
		.dvs_s1   (dvs_w[0])
	);

	assign rem_w[0] = '0;

	// restoring division stages
	for (genvar g = 0; g < N_STAGES; g++) begin : g_stage
		rsd_div_stage #(
			.STEPS (STEPS_PER_STAGE)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_w[g]),
			.num_in (num_w[g]),
			.rem_in (rem_w[g]),
			.dvs_in (dvs_w[g]),
			.ctl_sn (ctl_w[g+1]),
			.num_sn (num_w[g+1]),
			.rem_sn (rem_w[g+1]),
			.dvs_sn (dvs_w[g+1])
		);
	end

	// sign and result register
	rsd_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_in     (ctl_w[N_STAGES]),
		.num_in     (num_w[N_STAGES]),
		.done_q     (done),
		.quotient_q (quotient)
	);

endmodule

### hdl/rsd_checker.sv
module rsd_checker
	import rsd_pkg::*;
#(
	parameter int unsigned LATENCY = 2
)
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic signed [RSD_DVD_W-1:0] dividend,
	input logic signed [RSD_DVS_W-1:0] divisor,
	input logic                        done,
	input logic signed [RSD_QUO_W-1:0] quotient
);

	// the pipeline never refuses a request
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every accepted request is answered by a result strobe
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result strobe missing");

	// no result without a request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LATENCY !done)
		else $error("result strobe without request");

	// zero divisor gives zero
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && divisor == '0) |-> ##LATENCY (quotient == '0))
		else $error("zero divisor gave nonzero quotient");

	// unit divisor passes the low dividend bits through
	a_unit_div: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && divisor == 1) |-> ##LATENCY
		(quotient == $past(dividend[RSD_QUO_W-1:0], LATENCY)))
		else $error("unit divisor gave wrong quotient");

endmodule

bind rounded_signed_divide_64by32 rsd_checker #(
	.LATENCY (LATENCY)
) u_rsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.dividend (dividend),
	.divisor  (divisor),
	.done     (done),
	.quotient (quotient)
);
